// ----- hw/rtl/pcm_s24_pkg.sv -----
// shared types and constants for the pcm sample to s24 packer
// no dependencies
package pcm_s24_pkg;

   localparam int unsigned CsrIdxWidth = 1;
   localparam int unsigned CsrDataWidth = 2;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_SOURCE_FORMAT = 1'b0,
      CSR_DEST_FORMAT   = 1'b1
   } csr_index_type;

   typedef enum logic {
      SRC_FLOAT32 = 1'b0,
      SRC_S16     = 1'b1
   } src_format_type;

   typedef enum logic [1:0] {
      DST_S24_3 = 2'd0,
      DST_S24_4 = 2'd1,
      DST_S16   = 2'd2,
      DST_NONE  = 2'd3
   } dst_format_type;

   localparam logic [23:0] FullScale = 24'd8388607;
   localparam logic [23:0] MaxPos = 24'h7fffff;
   localparam logic [23:0] MinNeg = 24'h800000;

   typedef struct packed {
      logic [31:0] sample_word;
      logic        last_in_buffer;
   } req_type;

   typedef struct packed {
      logic [31:0] packed_word;
      logic [2:0]  byte_count;
      logic        last_out;
   } rsp_type;

   // stage one to stage two hand-off
   typedef struct packed {
      logic        valid;
      logic        last;
      logic        forced;      // result fixed, skip multiply
      logic [23:0] forced_val;
      logic        neg;
      logic [7:0]  expo;
      logic [23:0] mant;        // with hidden bit
   } s1_type;

endpackage

// ----- hw/rtl/pcm_s24_decode.sv -----
// stage 1: unpacks the source word, handles nan, clamp, zero and s16 paths
// depends on pcm_s24_pkg
module pcm_s24_decode
   import pcm_s24_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   input  req_type        in_item,
   input  src_format_type src_fmt,
   output s1_type         out_ff
);

   s1_type      out_in;
   logic [31:0] w;
   logic [7:0]  e;
   logic [22:0] f;
   logic [15:0] s16;

   always_comb begin
      w = in_item.sample_word;
      e = w[30:23];
      f = w[22:0];
      s16 = w[15:0];
      out_in = '0;
      out_in.valid = in_valid;
      out_in.last = in_item.last_in_buffer;
      out_in.neg = w[31];
      out_in.expo = e;
      out_in.mant = {1'b1, f};
      if (src_fmt == SRC_S16) begin
         out_in.forced = 1'b1;
         out_in.forced_val = {s16, 8'h00};
      end else if (e == 8'hff && f != 23'd0) begin
         out_in.forced = 1'b1;
         out_in.forced_val = MinNeg;
      end else if (e == 8'd0) begin
         out_in.forced = 1'b1;
         out_in.forced_val = 24'd0;
      end else if (e >= 8'd127) begin
         // magnitude at least one: clamps to full scale
         out_in.forced = 1'b1;
         out_in.forced_val = w[31] ? (~FullScale + 24'd1) : FullScale;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else begin
         out_ff.valid <= out_in.valid;
      end
      out_ff.last <= out_in.last;
      out_ff.forced <= out_in.forced;
      out_ff.forced_val <= out_in.forced_val;
      out_ff.neg <= out_in.neg;
      out_ff.expo <= out_in.expo;
      out_ff.mant <= out_in.mant;
   end

endmodule

// ----- hw/rtl/pcm_s24_round.sv -----
// stages 2 and 3: multiply by full scale, round to single, round to integer
// depends on pcm_s24_pkg
module pcm_s24_round
   import pcm_s24_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  s1_type      in_s1,
   output logic        out_valid_ff,
   output logic        out_last_ff,
   output logic [23:0] out_val_ff
);

   // stage 2 registers
   logic        v2_ff;
   logic        last2_ff;
   logic        forced2_ff;
   logic [23:0] fval2_ff;
   logic        neg2_ff;
   logic [7:0]  expo2_ff;
   logic [46:0] prod2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= in_s1.valid;
      end
      last2_ff <= in_s1.last;
      forced2_ff <= in_s1.forced;
      fval2_ff <= in_s1.forced_val;
      neg2_ff <= in_s1.neg;
      expo2_ff <= in_s1.expo;
      prod2_ff <= in_s1.mant * FullScale;
   end

   // round product to 24 significant bits, ties to even
   logic        top;
   logic [23:0] sig;
   logic [22:0] rest;
   logic        rbit;
   logic        sticky;
   logic [24:0] sig_r;
   logic [23:0] sig_n;
   logic [8:0]  ex;      // exponent of the rounded product, biased
   logic [4:0]  sh;
   logic [47:0] ext;
   logic [23:0] q;
   logic        qr;
   logic        qs;
   logic [23:0] mag;
   logic [23:0] val_in;

   always_comb begin
      top = prod2_ff[46];
      sig = top ? prod2_ff[46:23] : prod2_ff[45:22];
      rest = top ? prod2_ff[22:0] : {prod2_ff[21:0], 1'b0};
      rbit = rest[22];
      sticky = |rest[21:0];
      sig_r = {1'b0, sig} + {24'd0, rbit & (sticky | sig[0])};
      if (sig_r[24]) begin
         sig_n = 24'h800000;
      end else begin
         sig_n = sig_r[23:0];
      end
      // rounded product = sig_n * 2^(ex - 128)
      ex = {1'b0, expo2_ff} + {8'd0, top} + {8'd0, sig_r[24]};
      // integer part is sig_n >> (128 - ex), shift range 0..25
      if (ex >= 9'd128) begin
         sh = 5'd0;
      end else if ((9'd128 - ex) > 9'd25) begin
         sh = 5'd25;
      end else begin
         sh = 5'((9'd128 - ex));
      end
      ext = {sig_n, 24'd0} >> sh;
      q = ext[47:24];
      qr = ext[23];
      qs = |ext[22:0];
      mag = q + {23'd0, qr & (qs | q[0])};
      if (forced2_ff) begin
         val_in = fval2_ff;
      end else begin
         val_in = neg2_ff ? (~mag + 24'd1) : mag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= v2_ff;
      end
      out_last_ff <= last2_ff;
      out_val_ff <= val_in;
   end

endmodule

// ----- hw/rtl/pcm_sample_to_s24_packer.sv -----
// top level of the pcm sample to s24 packer: csr, pipeline, output packing
// depends on pcm_s24_pkg, pcm_s24_decode, pcm_s24_round
//
// One item per clock. Stage one decodes the float or s16 word, stage two holds
// the 24x24 multiplier, stage three rounds, stage four packs. There is no flow
// control on the result side: each item appears on rsp_item for one cycle with
// rsp_valid and must be taken then. busy is always low.
module pcm_sample_to_s24_packer
   import pcm_s24_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  req_type                 req_item,
   output logic                    rsp_valid,
   output rsp_type                 rsp_item,
   input  logic                    csr_write,
   input  logic [CsrIdxWidth-1:0]  csr_index,
   input  logic [CsrDataWidth-1:0] csr_data
);

   src_format_type src_fmt_ff;
   dst_format_type dst_fmt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_fmt_ff <= SRC_FLOAT32;
         dst_fmt_ff <= DST_S24_3;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_SOURCE_FORMAT: src_fmt_ff <= src_format_type'(csr_data[0]);
            CSR_DEST_FORMAT:   dst_fmt_ff <= dst_format_type'(csr_data);
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   s1_type      s1;
   logic        v3;
   logic        last3;
   logic [23:0] val3;

   pcm_s24_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start),
      .in_item  (req_item),
      .src_fmt  (src_fmt_ff),
      .out_ff   (s1)
   );

   pcm_s24_round u_round (
      .clock        (clock),
      .reset        (reset),
      .in_s1        (s1),
      .out_valid_ff (v3),
      .out_last_ff  (last3),
      .out_val_ff   (val3)
   );

   rsp_type rsp_in;
   rsp_type rsp_ff;
   logic    rsp_valid_ff;

   always_comb begin
      rsp_in = '0;
      rsp_in.last_out = last3;
      unique case (dst_fmt_ff)
         DST_S24_3: begin
            rsp_in.packed_word = {8'd0, val3};
            rsp_in.byte_count = 3'd3;
         end
         DST_S24_4: begin
            rsp_in.packed_word = {{8{val3[23]}}, val3};
            rsp_in.byte_count = 3'd4;
         end
         DST_S16: begin
            rsp_in.packed_word = {16'd0, val3[23:8]};
            rsp_in.byte_count = 3'd2;
         end
         default: begin
            rsp_in.packed_word = '0;
            rsp_in.byte_count = 3'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= v3;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##4 rsp_valid)
      else $error("item lost in pipeline");
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(v3))
      else $error("result without item");
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.byte_count == 3'd0 |-> rsp_item.packed_word == 32'd0)
      else $error("bytes with zero count");

endmodule
